// ===== hdl/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants for the point rotator
// Config register codes, register word type and the flag bundle that travels
// between rotation cells.
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int REG_WIDTH = 16;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0]        t_cfg_idx;
    typedef logic signed [REG_WIDTH-1:0] t_reg;

    localparam t_cfg_idx REG_COS_PITCH = 3'd0;
    localparam t_cfg_idx REG_SIN_PITCH = 3'd1;
    localparam t_cfg_idx REG_COS_ROLL  = 3'd2;
    localparam t_cfg_idx REG_SIN_ROLL  = 3'd3;
    localparam t_cfg_idx REG_COS_YAW   = 3'd4;
    localparam t_cfg_idx REG_SIN_YAW   = 3'd5;

    // sideband that moves with each point down the cell chain
    typedef struct packed {
        logic valid;
        logic clipped;
    } t_cell_flags;

endpackage

// ===== hdl/prr_if.sv =====
// ----------------------------------------------------------------------------
// prr_if: channel interfaces of the point rotator
// Input point stream, output point stream and config write channel.
// ----------------------------------------------------------------------------
interface prr_in_if #(parameter int CW = 24);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface prr_out_if #(parameter int CW = 24);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] x_out;
    logic signed [CW-1:0] y_out;
    logic signed [CW-1:0] z_out;
    logic                 clipped;

    modport source (output valid, output x_out, output y_out, output z_out,
                    output clipped, input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out,
                    input clipped, output ready);
endinterface

interface prr_cfg_if;
    logic               valid;
    logic               ready;
    prr_pkg::t_cfg_idx  index;
    prr_pkg::t_reg      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/point_rotate_pitch_roll_yaw.sv =====
// ----------------------------------------------------------------------------
// point_rotate_pitch_roll_yaw: 3D point rotation, pitch then roll then yaw
// Three identical plane-rotation cells in a row, then an output skid stage.
// ----------------------------------------------------------------------------
//
//  channel  dir  modport      payload                           transfer when
//  -------  ---  -----------  --------------------------------  -------------------
//  i_pt     in   prr_in_if    x_in, y_in, z_in (Q15.8)          valid && ready
//  o_pt     out  prr_out_if   x_out, y_out, z_out, clipped      valid && ready
//  i_cfg    in   prr_cfg_if   index (0..5), data (Q1.14 coef)   valid && ready
//
//  One point per cycle sustained while o_pt.ready holds; each cell runs four
//  multipliers in parallel and the multiply stage sets that rate.
//  Registered path: products and rotated pair in each cell, then the output stage.
//  Reset (sync, active low) empties the chain and loads the identity rotation.
//  Stalls: each stage holds only while full and blocked, so bubbles close up;
//  the output stage holds two points, and i_cfg never stalls.
//
module point_rotate_pitch_roll_yaw #(
    parameter int COORD_WIDTH    = 24,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    prr_in_if.sink               i_pt,
    prr_out_if.source            o_pt,
    prr_cfg_if.sink              i_cfg
);
    import prr_pkg::*;

    // coefficient regs widen when 1.0 no longer fits in the 16-bit word
    localparam int CoefW = (COEF_FRAC_BITS + 2 > REG_WIDTH) ? COEF_FRAC_BITS + 2 : REG_WIDTH;
    localparam logic signed [CoefW-1:0] CoefOne = CoefW'(1) << COEF_FRAC_BITS;
    localparam int DW = 3 * COORD_WIDTH + 1;

    // ---------------- config registers ----------------
    logic signed [CoefW-1:0] r_cos_pitch, r_sin_pitch;
    logic signed [CoefW-1:0] r_cos_roll,  r_sin_roll;
    logic signed [CoefW-1:0] r_cos_yaw,   r_sin_yaw;
    logic signed [CoefW-1:0] w_cfg_val;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_val   = CoefW'(i_cfg.data);   // sign extend

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_pitch <= CoefOne;
            r_sin_pitch <= '0;
            r_cos_roll  <= CoefOne;
            r_sin_roll  <= '0;
            r_cos_yaw   <= CoefOne;
            r_sin_yaw   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_COS_PITCH: r_cos_pitch <= w_cfg_val;
                REG_SIN_PITCH: r_sin_pitch <= w_cfg_val;
                REG_COS_ROLL:  r_cos_roll  <= w_cfg_val;
                REG_SIN_ROLL:  r_sin_roll  <= w_cfg_val;
                REG_COS_YAW:   r_cos_yaw   <= w_cfg_val;
                REG_SIN_YAW:   r_sin_yaw   <= w_cfg_val;
                default: ;     // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- cell chain ----------------
    // Each cell rotates a pair (a, b) as a' = c*a - s*b, b' = s*a + c*b.
    //   pitch: (a, b, pass) = (y, z, x)
    //   roll:  (a, b, pass) = (z, x, y)   -> x' = s*z + c*x, z' = c*z - s*x
    //   yaw:   (a, b, pass) = (x, y, z)
    t_cell_flags w_flg_in, w_flg_p, w_flg_r, w_flg_y;
    logic        w_rdy_r, w_rdy_y, w_rdy_o;
    logic signed [COORD_WIDTH-1:0] w_y1, w_z1, w_x1;
    logic signed [COORD_WIDTH-1:0] w_z2, w_x2, w_y2;
    logic signed [COORD_WIDTH-1:0] w_x3, w_y3, w_z3;

    assign w_flg_in.valid   = i_pt.valid;
    assign w_flg_in.clipped = 1'b0;

    prr_cell #(.CW(COORD_WIDTH), .KW(CoefW), .FRAC(COEF_FRAC_BITS)) u_pitch (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cos  (r_cos_pitch),
        .i_sin  (r_sin_pitch),
        .i_flg  (w_flg_in),
        .o_rdy  (i_pt.ready),
        .i_a    (i_pt.y_in),
        .i_b    (i_pt.z_in),
        .i_c    (i_pt.x_in),
        .o_flg  (w_flg_p),
        .i_rdy  (w_rdy_r),
        .o_a    (w_y1),
        .o_b    (w_z1),
        .o_c    (w_x1)
    );

    prr_cell #(.CW(COORD_WIDTH), .KW(CoefW), .FRAC(COEF_FRAC_BITS)) u_roll (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cos  (r_cos_roll),
        .i_sin  (r_sin_roll),
        .i_flg  (w_flg_p),
        .o_rdy  (w_rdy_r),
        .i_a    (w_z1),
        .i_b    (w_x1),
        .i_c    (w_y1),
        .o_flg  (w_flg_r),
        .i_rdy  (w_rdy_y),
        .o_a    (w_z2),
        .o_b    (w_x2),
        .o_c    (w_y2)
    );

    prr_cell #(.CW(COORD_WIDTH), .KW(CoefW), .FRAC(COEF_FRAC_BITS)) u_yaw (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cos  (r_cos_yaw),
        .i_sin  (r_sin_yaw),
        .i_flg  (w_flg_r),
        .o_rdy  (w_rdy_y),
        .i_a    (w_x2),
        .i_b    (w_y2),
        .i_c    (w_z2),
        .o_flg  (w_flg_y),
        .i_rdy  (w_rdy_o),
        .o_a    (w_x3),
        .o_b    (w_y3),
        .o_c    (w_z3)
    );

    // ---------------- output stage ----------------
    logic [DW-1:0] w_out_data;

    prr_skid #(.DW(DW)) u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_flg_y.valid),
        .o_rdy  (w_rdy_o),
        .i_data ({w_x3, w_y3, w_z3, w_flg_y.clipped}),
        .o_vld  (o_pt.valid),
        .i_rdy  (o_pt.ready),
        .o_data (w_out_data)
    );

    assign o_pt.x_out   = w_out_data[DW-1 -: COORD_WIDTH];
    assign o_pt.y_out   = w_out_data[DW-1-COORD_WIDTH -: COORD_WIDTH];
    assign o_pt.z_out   = w_out_data[COORD_WIDTH:1];
    assign o_pt.clipped = w_out_data[0];

endmodule

// ===== hdl/prr_cell.sv =====
// ----------------------------------------------------------------------------
// prr_cell: one plane rotation cell
// a' = rnd(c*a) + rnd(-s*b), b' = rnd(s*a) + rnd(c*b), third coordinate passes.
// Two stages: products, then round/add/saturate.
// ----------------------------------------------------------------------------
module prr_cell #(
    parameter int CW   = 24,
    parameter int KW   = 16,
    parameter int FRAC = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [KW-1:0] i_cos,
    input  logic signed [KW-1:0] i_sin,
    input  prr_pkg::t_cell_flags i_flg,
    output logic                 o_rdy,
    input  logic signed [CW-1:0] i_a,
    input  logic signed [CW-1:0] i_b,
    input  logic signed [CW-1:0] i_c,
    output prr_pkg::t_cell_flags o_flg,
    input  logic                 i_rdy,
    output logic signed [CW-1:0] o_a,
    output logic signed [CW-1:0] o_b,
    output logic signed [CW-1:0] o_c
);
    import prr_pkg::*;

    localparam int NW = KW + 1;   // holds -sin for any sin
    localparam int PW = CW + NW;  // exact product
    localparam int RW = PW + 1;   // product plus rounding half
    localparam int SW = RW + 1;   // sum of two rounded terms
    localparam logic signed [RW-1:0] Half = RW'(1) << (FRAC - 1);
    localparam logic signed [CW-1:0] CoordMax = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CoordMin = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [RW-1:0] t;
        t = RW'(p) + Half;
        return t >>> FRAC;
    endfunction

    function automatic logic fits(input logic signed [SW-1:0] v);
        return (&v[SW-1:CW-1]) || !(|v[SW-1:CW-1]);
    endfunction

    logic signed [NW-1:0] w_c, w_s, w_ns;
    logic signed [PW-1:0] w_p_ca, w_p_nsb, w_p_sa, w_p_cb;

    assign w_c  = NW'(i_cos);
    assign w_s  = NW'(i_sin);
    assign w_ns = -w_s;

    assign w_p_ca  = w_c  * i_a;
    assign w_p_nsb = w_ns * i_b;
    assign w_p_sa  = w_s  * i_a;
    assign w_p_cb  = w_c  * i_b;

    // stage 1: products
    t_cell_flags          r_flg1;
    logic signed [PW-1:0] r_p_ca, r_p_nsb, r_p_sa, r_p_cb;
    logic signed [CW-1:0] r_c1;

    // stage 2: rotated pair
    t_cell_flags          r_flg2;
    logic signed [CW-1:0] r_a2, r_b2, r_c2;

    logic                 w_en1, w_en2;
    logic signed [SW-1:0] w_sum_a, w_sum_b;
    logic                 w_fit_a, w_fit_b;
    logic signed [CW-1:0] n_a2, n_b2;

    assign w_en2 = !r_flg2.valid || i_rdy;
    assign w_en1 = !r_flg1.valid || w_en2;
    assign o_rdy = w_en1;

    always_comb begin
        w_sum_a = SW'(rnd(r_p_ca)) + SW'(rnd(r_p_nsb));
        w_sum_b = SW'(rnd(r_p_sa)) + SW'(rnd(r_p_cb));
        w_fit_a = fits(w_sum_a);
        w_fit_b = fits(w_sum_b);
        n_a2 = w_fit_a ? w_sum_a[CW-1:0] : (w_sum_a[SW-1] ? CoordMin : CoordMax);
        n_b2 = w_fit_b ? w_sum_b[CW-1:0] : (w_sum_b[SW-1] ? CoordMin : CoordMax);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flg1 <= '0;
            r_flg2 <= '0;
        end else begin
            if (w_en1) begin
                r_flg1 <= i_flg;
            end
            if (w_en2) begin
                r_flg2.valid   <= r_flg1.valid;
                r_flg2.clipped <= r_flg1.clipped || !w_fit_a || !w_fit_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_p_ca  <= w_p_ca;
            r_p_nsb <= w_p_nsb;
            r_p_sa  <= w_p_sa;
            r_p_cb  <= w_p_cb;
            r_c1    <= i_c;
        end
        if (w_en2) begin
            r_a2 <= n_a2;
            r_b2 <= n_b2;
            r_c2 <= r_c1;
        end
    end

    assign o_flg = r_flg2;
    assign o_a   = r_a2;
    assign o_b   = r_b2;
    assign o_c   = r_c2;

endmodule

// ===== hdl/prr_skid.sv =====
// ----------------------------------------------------------------------------
// prr_skid: output register with skid slot
// Upstream ready comes from a register, so the sink's ready never reaches
// the cell chain combinationally.
// ----------------------------------------------------------------------------
module prr_skid #(
    parameter int DW = 73
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  logic [DW-1:0] i_data,
    output logic          o_vld,
    input  logic          i_rdy,
    output logic [DW-1:0] o_data
);
    logic          r_vld, r_skid_vld;
    logic [DW-1:0] r_data, r_skid;
    logic          w_main_free;

    assign w_main_free = i_rdy || !r_vld;
    assign o_rdy       = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_main_free) begin
            if (r_skid_vld) begin
                r_vld      <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_vld <= i_vld;
            end
        end else if (i_vld && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_main_free) begin
            if (r_skid_vld) begin
                r_data <= r_skid;
            end else if (i_vld) begin
                r_data <= i_data;
            end
        end else if (i_vld && !r_skid_vld) begin
            r_skid <= i_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

// ===== hdl/prr_chk.sv =====
// ----------------------------------------------------------------------------
// prr_chk: port-level checks for the point rotator
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module prr_chk #(
    parameter int CW = 24
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [CW-1:0] i_out_x,
    input logic [CW-1:0] i_out_y,
    input logic [CW-1:0] i_out_z,
    input logic          i_out_clip
);
    // a result offered and not taken stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_z) && $stable(i_out_clip))
        else $error("output payload changed while stalled");

    // reset empties the chain: nothing offered afterwards
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // an empty chain takes a point at once
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind point_rotate_pitch_roll_yaw prr_chk #(.CW(COORD_WIDTH)) u_prr_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_pt.ready),
    .i_out_valid(o_pt.valid),
    .i_out_ready(o_pt.ready),
    .i_out_x    (o_pt.x_out),
    .i_out_y    (o_pt.y_out),
    .i_out_z    (o_pt.z_out),
    .i_out_clip (o_pt.clipped)
);
